FILE: design/assert_macros.svh
// Assertion helpers shared by the score panel RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SCP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SCP_NEVER(lbl, clk, rst_n, cond, msg) \
  `SCP_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: design/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types, constants and display helpers for the score panel.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

  // Timer and score limits
  localparam logic [15:0] TIMER_MAX = 16'hFFFF;
  localparam logic [6:0]  SCORE_MAX = 7'd99;

  // Blink runs on a 500-tick period, drawn for the first 250 ticks
  localparam logic [8:0] BLINK_LAST = 9'd499;
  localparam logic [8:0] BLINK_ON   = 9'd250;

  // Segment patterns
  localparam logic [7:0] SEG_MINUS = 8'b0100_0000;
  localparam logic [7:0] SEG_DOT   = 8'b1000_0000;
  localparam logic [7:0] SEG_BLANK = 8'b0000_0000;

  // Register reset values
  localparam logic [6:0]  RST_START    = 7'd20;
  localparam logic [15:0] RST_DEBOUNCE = 16'd50;
  localparam logic [15:0] RST_HOLD     = 16'd500;
  localparam logic [15:0] RST_REPEAT   = 16'd200;
  localparam logic [15:0] RST_TIMEOUT  = 16'd2000;
  localparam logic [2:0]  RST_BRIGHT   = 3'd4;
  localparam logic [2:0]  RST_DIM      = 3'd2;

  // Register indexes (byte address / 4)
  typedef enum logic [2:0] {
    REG_START    = 3'd0,
    REG_DEBOUNCE = 3'd1,
    REG_HOLD     = 3'd2,
    REG_REPEAT   = 3'd3,
    REG_TIMEOUT  = 3'd4,
    REG_BRIGHT   = 3'd5,
    REG_DIM      = 3'd6
  } reg_idx_t;

  // Panel mode
  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_LEFT  = 2'd1,
    MODE_RIGHT = 2'd2
  } mode_t;

  // Button timing settings
  typedef struct packed {
    logic [15:0] debounce;
    logic [15:0] hold;
    logic [15:0] rpt;
  } btn_cfg_t;

  // Button status for the current tick
  typedef struct packed {
    logic click;  // press produced a click this tick
    logic armed;  // new press timer has reached the debounce time
  } btn_stat_t;

  // Seven-segment pattern of one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] seg;
    unique case (d)
      4'd0:    seg = 8'b0011_1111;
      4'd1:    seg = 8'b0000_0110;
      4'd2:    seg = 8'b0101_1011;
      4'd3:    seg = 8'b0100_1111;
      4'd4:    seg = 8'b0110_0110;
      4'd5:    seg = 8'b0110_1101;
      4'd6:    seg = 8'b0111_1101;
      4'd7:    seg = 8'b0000_0111;
      4'd8:    seg = 8'b0111_1111;
      4'd9:    seg = 8'b0110_1111;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // Tens and units patterns {tens, units} of a score up to 99
  function automatic logic [15:0] seg_pair(input logic [6:0] s, input logic draw);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    logic [7:0]  hi;
    logic [7:0]  lo;
    // tens = floor(s * 205 / 2048), exact for s below 100
    prod  = 15'(s) * 15'd205;
    tens  = prod[14:11];
    units = s - 7'(tens) * 7'd10;
    if (!draw) begin
      hi = SEG_BLANK;
      lo = SEG_DOT;
    end else if (s == 7'd0) begin
      hi = SEG_MINUS;
      lo = SEG_MINUS | SEG_DOT;
    end else begin
      hi = seg_of(tens);
      lo = seg_of(units[3:0]) | SEG_DOT;
    end
    return {hi, lo};
  endfunction

endpackage

`default_nettype wire

FILE: design/scp_button.sv
// ----------------------------------------------------------------------------
// scp_button
// Debounce and auto-repeat timing for one button.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_button (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              advance,
  input  wire logic              pressed,
  input  wire scp_pkg::btn_cfg_t cfg,
  output scp_pkg::btn_stat_t     stat
);

  logic [15:0] timer_r, timer_nxt;
  logic [15:0] phase_r, phase_nxt;
  logic [15:0] timer_inc;
  logic [16:0] phase_inc;
  logic        moved;

  // Advance the saturating press timer and the repeat phase
  always_comb begin
    moved     = (timer_r != scp_pkg::TIMER_MAX);
    timer_inc = timer_r + 16'd1;
    phase_inc = {1'b0, phase_r} + 17'd1;
    timer_nxt = timer_r;
    phase_nxt = phase_r;
    if (!pressed) begin
      timer_nxt = '0;
      phase_nxt = '0;
    end else if (moved) begin
      timer_nxt = timer_inc;
      if (timer_inc <= cfg.hold) begin
        phase_nxt = '0;
      end else if (phase_inc >= {1'b0, cfg.rpt}) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_inc[15:0];
      end
    end
  end

  // Click at debounce time, then at each repeat point from the hold time on
  always_comb begin
    stat.armed = (timer_nxt >= cfg.debounce);
    stat.click = pressed && moved && stat.armed &&
                 ((timer_nxt == cfg.debounce) ||
                  ((timer_nxt >= cfg.hold) && (phase_nxt == 16'd0)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_r <= '0;
      phase_r <= '0;
    end else if (advance) begin
      timer_r <= timer_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/two_button_score_panel.sv
// ----------------------------------------------------------------------------
// two_button_score_panel
// Two-button score keeper with debounced auto-repeat and 7-segment output.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick with both button levels. The item
// is folded into the timer, score and mode registers and the display bytes
// are captured in an output register, all in the cycle it is accepted, so an
// item can be taken every clock; a result appears in the cycle after its item.
// The input side stays ready while the output register is empty or being
// drained, so throughput is one item per cycle as long as out_ready is high.
// Registers sit on an APB-style port at byte addresses 0x00..0x18; write them
// only while no item is in flight. Reads return the stored value.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module two_button_score_panel (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // tick items
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_left_pressed,
  input  wire logic        in_right_pressed,
  // display results
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_seg_left_tens,
  output logic [7:0]       out_seg_left_units,
  output logic [7:0]       out_seg_right_tens,
  output logic [7:0]       out_seg_right_units,
  output logic [2:0]       out_level_out,
  output logic [1:0]       out_mode_out,
  output logic [6:0]       out_left_value,
  output logic [6:0]       out_right_value,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  // Configuration registers
  logic [6:0]  start_r;
  logic [15:0] debounce_r;
  logic [15:0] hold_r;
  logic [15:0] repeat_r;
  logic [15:0] timeout_r;
  logic [2:0]  bright_r;
  logic [2:0]  dim_r;

  // Panel state
  logic [15:0]     tick_r, tick_nxt;
  logic [8:0]      blink_r, blink_nxt;
  logic [15:0]     last_r, last_nxt;
  logic [6:0]      score_l_r, score_l_nxt;
  logic [6:0]      score_r_r, score_r_nxt;
  scp_pkg::mode_t  mode_r, mode_nxt;
  logic [2:0]      level_r, level_nxt;

  // Output register
  logic            out_valid_r;
  logic [15:0]     seg_l_r, seg_l_nxt;
  logic [15:0]     seg_r_r, seg_r_nxt;

  logic              accept;
  logic              cfg_wr;
  logic [6:0]        load_score;
  logic [15:0]       since_click;
  logic              dual;
  scp_pkg::reg_idx_t cfg_idx;
  scp_pkg::btn_cfg_t btn_cfg;
  scp_pkg::btn_stat_t stat_l;
  scp_pkg::btn_stat_t stat_r;

  assign accept     = in_valid && in_ready;
  assign in_ready   = !out_valid_r || out_ready;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = scp_pkg::reg_idx_t'(cfg_paddr[4:2]);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r    <= scp_pkg::RST_START;
      debounce_r <= scp_pkg::RST_DEBOUNCE;
      hold_r     <= scp_pkg::RST_HOLD;
      repeat_r   <= scp_pkg::RST_REPEAT;
      timeout_r  <= scp_pkg::RST_TIMEOUT;
      bright_r   <= scp_pkg::RST_BRIGHT;
      dim_r      <= scp_pkg::RST_DIM;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        scp_pkg::REG_START:    start_r    <= cfg_pwdata[6:0];
        scp_pkg::REG_DEBOUNCE: debounce_r <= cfg_pwdata[15:0];
        scp_pkg::REG_HOLD:     hold_r     <= cfg_pwdata[15:0];
        scp_pkg::REG_REPEAT:   repeat_r   <= cfg_pwdata[15:0];
        scp_pkg::REG_TIMEOUT:  timeout_r  <= cfg_pwdata[15:0];
        scp_pkg::REG_BRIGHT:   bright_r   <= cfg_pwdata[2:0];
        scp_pkg::REG_DIM:      dim_r      <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    unique case (cfg_idx)
      scp_pkg::REG_START:    cfg_prdata = {25'd0, start_r};
      scp_pkg::REG_DEBOUNCE: cfg_prdata = {16'd0, debounce_r};
      scp_pkg::REG_HOLD:     cfg_prdata = {16'd0, hold_r};
      scp_pkg::REG_REPEAT:   cfg_prdata = {16'd0, repeat_r};
      scp_pkg::REG_TIMEOUT:  cfg_prdata = {16'd0, timeout_r};
      scp_pkg::REG_BRIGHT:   cfg_prdata = {29'd0, bright_r};
      scp_pkg::REG_DIM:      cfg_prdata = {29'd0, dim_r};
      default:               cfg_prdata = '0;
    endcase
  end

  // Button timing
  assign btn_cfg = '{debounce: debounce_r, hold: hold_r, rpt: repeat_r};

  scp_button u_btn_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .pressed (in_left_pressed),
    .cfg     (btn_cfg),
    .stat    (stat_l)
  );

  scp_button u_btn_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .pressed (in_right_pressed),
    .cfg     (btn_cfg),
    .stat    (stat_r)
  );

  // Clamp the start score
  assign load_score = (start_r > scp_pkg::SCORE_MAX) ? scp_pkg::SCORE_MAX : start_r;

  // Advance tick count and its blink phase (tick count mod 500)
  always_comb begin
    tick_nxt = tick_r + 16'd1;
    if (tick_nxt == 16'd0 || blink_r == scp_pkg::BLINK_LAST) begin
      blink_nxt = '0;
    end else begin
      blink_nxt = blink_r + 9'd1;
    end
  end

  // Apply left click, then right click or dual press, then timeout
  always_comb begin
    mode_nxt    = mode_r;
    level_nxt   = level_r;
    score_l_nxt = score_l_r;
    score_r_nxt = score_r_r;
    last_nxt    = last_r;
    dual        = in_right_pressed && stat_r.armed && stat_l.armed;

    // left button: select left or subtract one
    if (stat_l.click) begin
      if (mode_nxt == scp_pkg::MODE_IDLE) begin
        mode_nxt  = scp_pkg::MODE_LEFT;
        level_nxt = bright_r;
      end else if (mode_nxt == scp_pkg::MODE_RIGHT) begin
        if (score_r_nxt != 7'd0) score_r_nxt = score_r_nxt - 7'd1;
      end else begin
        if (score_l_nxt != 7'd0) score_l_nxt = score_l_nxt - 7'd1;
      end
      last_nxt = tick_nxt;
    end

    // right button: dual press restores scores and drops to idle, else select right or add one
    if (dual) begin
      score_l_nxt = load_score;
      score_r_nxt = load_score;
      mode_nxt    = scp_pkg::MODE_IDLE;
      level_nxt   = dim_r;
    end else if (stat_r.click) begin
      if (mode_nxt == scp_pkg::MODE_IDLE) begin
        mode_nxt  = scp_pkg::MODE_RIGHT;
        level_nxt = bright_r;
      end else if (mode_nxt == scp_pkg::MODE_RIGHT) begin
        if (score_r_nxt < scp_pkg::SCORE_MAX) score_r_nxt = score_r_nxt + 7'd1;
      end else begin
        if (score_l_nxt < scp_pkg::SCORE_MAX) score_l_nxt = score_l_nxt + 7'd1;
      end
      last_nxt = tick_nxt;
    end

    // drop back to idle once no click came for the timeout
    since_click = tick_nxt - last_nxt;
    if (mode_nxt != scp_pkg::MODE_IDLE && since_click >= timeout_r) begin
      mode_nxt  = scp_pkg::MODE_IDLE;
      level_nxt = dim_r;
    end
  end

  // Form the digit patterns, blinking the selected side
  always_comb begin
    seg_l_nxt = scp_pkg::seg_pair(score_l_nxt,
                  (mode_nxt != scp_pkg::MODE_LEFT) || (blink_nxt < scp_pkg::BLINK_ON));
    seg_r_nxt = scp_pkg::seg_pair(score_r_nxt,
                  (mode_nxt != scp_pkg::MODE_RIGHT) || (blink_nxt < scp_pkg::BLINK_ON));
  end

  // Panel state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      blink_r   <= '0;
      last_r    <= '0;
      score_l_r <= scp_pkg::RST_START;
      score_r_r <= scp_pkg::RST_START;
      mode_r    <= scp_pkg::MODE_IDLE;
      level_r   <= scp_pkg::RST_DIM;
    end else if (accept) begin
      tick_r    <= tick_nxt;
      blink_r   <= blink_nxt;
      last_r    <= last_nxt;
      score_l_r <= score_l_nxt;
      score_r_r <= score_r_nxt;
      mode_r    <= mode_nxt;
      level_r   <= level_nxt;
    end
  end

  // Output valid: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      seg_l_r <= seg_l_nxt;
      seg_r_r <= seg_r_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_seg_left_tens   = seg_l_r[15:8];
  assign out_seg_left_units  = seg_l_r[7:0];
  assign out_seg_right_tens  = seg_r_r[15:8];
  assign out_seg_right_units = seg_r_r[7:0];
  assign out_level_out       = level_r;
  assign out_mode_out        = mode_r;
  assign out_left_value      = score_l_r;
  assign out_right_value     = score_r_r;

  // Checks
  `SCP_NEVER(a_score_range, clk, rst_n,
    (score_l_r > scp_pkg::SCORE_MAX) || (score_r_r > scp_pkg::SCORE_MAX), "score above 99")
  `SCP_NEVER(a_blink_range, clk, rst_n, blink_r > scp_pkg::BLINK_LAST, "blink phase past 499")
  `SCP_ASSERT(a_tick_step, clk, rst_n,
    accept |=> (tick_r == $past(tick_r) + 16'd1), "tick count did not advance")
  `SCP_ASSERT(a_result_follows, clk, rst_n, accept |=> out_valid_r, "accepted item gave no result")

endmodule

`default_nettype wire

FILE: bench/two_button_score_panel_tb.sv
// ----------------------------------------------------------------------------
// two_button_score_panel_tb
// Drives tick items through the score panel and checks every display item.
// A tracker class keeps its own copy of the button timers, scores, mode and
// register settings, predicts the display for each accepted tick and compares
// it field by field. Both sides idle at random; registers change only when
// no display is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module two_button_score_panel_tb;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned UNUSED_REG   = 7;
  localparam int unsigned BLINK_PERIOD = 500;
  localparam int unsigned BLINK_SHOWN  = 250;
  localparam int unsigned TOP_SCORE    = 99;
  localparam int unsigned TIMER_TOP    = 'hFFFF;
  localparam logic [7:0]  DOT_BIT      = 8'h80;
  localparam logic [7:0]  DASH         = 8'h40;

  // One display item
  typedef struct {
    logic [7:0] seg_left_tens;
    logic [7:0] seg_left_units;
    logic [7:0] seg_right_tens;
    logic [7:0] seg_right_units;
    logic [2:0] level_out;
    logic [1:0] mode_out;
    logic [6:0] left_value;
    logic [6:0] right_value;
  } panel_view_t;

  // Tracks panel state and holds the displays still to come
  class panel_tracker;
    int unsigned     start_cfg, debounce_cfg, hold_cfg, repeat_cfg;
    int unsigned     timeout_cfg, bright_cfg, dim_cfg;
    int unsigned     tick_cnt, last_click;
    int unsigned     held[2];
    int unsigned     phase[2];
    int unsigned     score[2];
    scp_pkg::mode_t  mode;
    logic [2:0]      level;
    panel_view_t     due_views[$];
    int unsigned     ticks_seen, views_checked, errors;

    function new();
      start_cfg = 20; debounce_cfg = 50; hold_cfg = 500; repeat_cfg = 200;
      timeout_cfg = 2000; bright_cfg = 4; dim_cfg = 2;
      tick_cnt = 0; last_click = 0;
      held[0] = 0; held[1] = 0; phase[0] = 0; phase[1] = 0;
      score[0] = loaded_score(); score[1] = loaded_score();
      mode = scp_pkg::MODE_IDLE;
      level = dim_cfg[2:0];
      ticks_seen = 0; views_checked = 0; errors = 0;
    endfunction

    function int unsigned loaded_score();
      return (start_cfg > TOP_SCORE) ? TOP_SCORE : start_cfg;
    endfunction

    function void set_reg(int unsigned idx, int unsigned value);
      case (idx)
        scp_pkg::REG_START:    start_cfg    = value & 'h7F;
        scp_pkg::REG_DEBOUNCE: debounce_cfg = value & 'hFFFF;
        scp_pkg::REG_HOLD:     hold_cfg     = value & 'hFFFF;
        scp_pkg::REG_REPEAT:   repeat_cfg   = value & 'hFFFF;
        scp_pkg::REG_TIMEOUT:  timeout_cfg  = value & 'hFFFF;
        scp_pkg::REG_BRIGHT:   bright_cfg   = value & 'h7;
        scp_pkg::REG_DIM:      dim_cfg      = value & 'h7;
        default: ;
      endcase
    endfunction

    function logic [7:0] digit_pattern(int unsigned d);
      case (d)
        0: return 8'h3F;
        1: return 8'h06;
        2: return 8'h5B;
        3: return 8'h4F;
        4: return 8'h66;
        5: return 8'h6D;
        6: return 8'h7D;
        7: return 8'h07;
        8: return 8'h7F;
        default: return 8'h6F;
      endcase
    endfunction

    // Advance one button: timer, repeat phase, dual press and click action
    function void button(int unsigned side, bit pressed);
      int unsigned t;
      int unsigned k;
      bit moved;
      bit click;
      if (!pressed) begin
        held[side] = 0;
        phase[side] = 0;
        return;
      end
      moved = held[side] < TIMER_TOP;
      if (moved) begin
        held[side]++;
        t = held[side];
        if (t <= hold_cfg) phase[side] = 0;
        else if (phase[side] + 1 >= repeat_cfg) phase[side] = 0;
        else phase[side]++;
      end
      t = held[side];
      if (t < debounce_cfg) return;
      // both buttons armed: restore scores and drop to idle
      if (side == 1 && held[0] >= debounce_cfg) begin
        score[0] = loaded_score();
        score[1] = loaded_score();
        mode = scp_pkg::MODE_IDLE;
        level = dim_cfg[2:0];
        return;
      end
      click = moved && (t == debounce_cfg || (t >= hold_cfg && phase[side] == 0));
      if (!click) return;
      if (mode == scp_pkg::MODE_IDLE) begin
        mode = side ? scp_pkg::MODE_RIGHT : scp_pkg::MODE_LEFT;
        level = bright_cfg[2:0];
      end else begin
        k = (mode == scp_pkg::MODE_RIGHT) ? 1 : 0;
        if (side == 1) begin
          if (score[k] < TOP_SCORE) score[k]++;
        end else if (score[k] > 0) begin
          score[k]--;
        end
      end
      last_click = tick_cnt;
    endfunction

    // Fold one accepted tick in and queue the display it produces
    function void note_tick(bit left_lvl, bit right_lvl);
      panel_view_t v;
      logic [15:0] since;
      logic [7:0]  hi[2];
      logic [7:0]  lo[2];
      bit          draw;
      int unsigned i;
      tick_cnt = (tick_cnt + 1) & TIMER_TOP;
      button(0, left_lvl);
      button(1, right_lvl);
      since = 16'(tick_cnt - last_click);
      if (mode != scp_pkg::MODE_IDLE && since >= timeout_cfg) begin
        mode = scp_pkg::MODE_IDLE;
        level = dim_cfg[2:0];
      end
      for (i = 0; i < 2; i++) begin
        draw = (mode != ((i == 0) ? scp_pkg::MODE_LEFT : scp_pkg::MODE_RIGHT)) ||
               (tick_cnt % BLINK_PERIOD < BLINK_SHOWN);
        if (!draw) begin
          hi[i] = 8'h00;
          lo[i] = DOT_BIT;
        end else if (score[i] == 0) begin
          hi[i] = DASH;
          lo[i] = DASH | DOT_BIT;
        end else begin
          hi[i] = digit_pattern((score[i] / 10) % 10);
          lo[i] = digit_pattern(score[i] % 10) | DOT_BIT;
        end
      end
      v.seg_left_tens   = hi[0];
      v.seg_left_units  = lo[0];
      v.seg_right_tens  = hi[1];
      v.seg_right_units = lo[1];
      v.level_out       = level;
      v.mode_out        = mode;
      v.left_value      = 7'(score[0]);
      v.right_value     = 7'(score[1]);
      due_views.push_back(v);
      ticks_seen++;
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_view(panel_view_t got);
      panel_view_t want;
      if (due_views.size() == 0) begin
        $error("display item arrived with no tick pending");
        errors++;
        return;
      end
      want = due_views.pop_front();
      views_checked++;
      compare("seg_left_tens",   want.seg_left_tens,   got.seg_left_tens);
      compare("seg_left_units",  want.seg_left_units,  got.seg_left_units);
      compare("seg_right_tens",  want.seg_right_tens,  got.seg_right_tens);
      compare("seg_right_units", want.seg_right_units, got.seg_right_units);
      compare("level_out",       8'(want.level_out),   8'(got.level_out));
      compare("mode_out",        8'(want.mode_out),    8'(got.mode_out));
      compare("left_value",      8'(want.left_value),  8'(got.left_value));
      compare("right_value",     8'(want.right_value), 8'(got.right_value));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_left_pressed = 1'b0;
  logic        in_right_pressed = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_seg_left_tens;
  logic [7:0]  out_seg_left_units;
  logic [7:0]  out_seg_right_tens;
  logic [7:0]  out_seg_right_units;
  logic [2:0]  out_level_out;
  logic [1:0]  out_mode_out;
  logic [6:0]  out_left_value;
  logic [6:0]  out_right_value;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  panel_tracker tracker = new();
  int unsigned  cycles = 0;
  int unsigned  reg_writes = 0;
  bit           quiet = 1'b0;

  two_button_score_panel uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_left_pressed     (in_left_pressed),
    .in_right_pressed    (in_right_pressed),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_seg_left_tens   (out_seg_left_tens),
    .out_seg_left_units  (out_seg_left_units),
    .out_seg_right_tens  (out_seg_right_tens),
    .out_seg_right_units (out_seg_right_units),
    .out_level_out       (out_level_out),
    .out_mode_out        (out_mode_out),
    .out_left_value      (out_left_value),
    .out_right_value     (out_right_value),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  always #6 clk = ~clk;

  // Watch both handshakes and bound the run
  always @(posedge clk) begin
    panel_view_t seen;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) tracker.note_tick(in_left_pressed, in_right_pressed);
      if (out_valid && out_ready) begin
        seen.seg_left_tens   = out_seg_left_tens;
        seen.seg_left_units  = out_seg_left_units;
        seen.seg_right_tens  = out_seg_right_tens;
        seen.seg_right_units = out_seg_right_units;
        seen.level_out       = out_level_out;
        seen.mode_out        = out_mode_out;
        seen.left_value      = out_left_value;
        seen.right_value     = out_right_value;
        tracker.check_view(seen);
      end
    end
  end

  // Stall the display side for a random number of cycles per item
  always begin
    int unsigned stall;
    stall = quiet ? 0 : $urandom_range(0, 17);
    if (stall != 0) begin
      out_ready <= 1'b0;
      repeat (stall) @(posedge clk);
    end
    out_ready <= 1'b1;
    @(posedge clk);
    while (!(out_valid && rst_n)) @(posedge clk);
  end

  // Offer one tick item after a random gap; hold valid until accepted
  task automatic send_tick(bit left_lvl, bit right_lvl);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_left_pressed  <= left_lvl;
    in_right_pressed <= right_lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold off new ticks until every pending display has drained
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.due_views.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic write_reg(int unsigned idx, int unsigned value);
    logic [31:0] want;
    logic [31:0] got;
    case (idx)
      scp_pkg::REG_START:                    want = value & 'h7F;
      scp_pkg::REG_BRIGHT, scp_pkg::REG_DIM: want = value & 'h7;
      default:                               want = value & 'hFFFF;
    endcase
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 5'(idx * 4);
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    tracker.set_reg(idx, value);
    reg_writes++;
    // turn the access into a read of the same address
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    got = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx <= scp_pkg::REG_DIM && got !== want) begin
      $error("register %0d readback: expected %0h, got %0h", idx, want, got);
      tracker.errors++;
    end
  endtask

  // New random settings, then press sequences with random content
  task automatic random_phase(int unsigned quota);
    int unsigned n;
    int unsigned w;
    int unsigned len;
    int unsigned span;
    int unsigned j;
    bit          left_lvl;
    bit          right_lvl;
    bit          noisy;
    wait_idle();
    w = $urandom_range(0, 3);
    write_reg(scp_pkg::REG_START, (w == 0) ? 0 : (w == 1) ? 99 : (w == 2) ? 127 :
                                  $urandom_range(0, 99));
    w = $urandom_range(0, 19);
    write_reg(scp_pkg::REG_DEBOUNCE,
              (w == 0) ? 0 : (w == 1) ? 65535 : $urandom_range(1, 4));
    write_reg(scp_pkg::REG_HOLD, $urandom_range(1, 12));
    write_reg(scp_pkg::REG_REPEAT, $urandom_range(0, 5));
    w = $urandom_range(0, 19);
    write_reg(scp_pkg::REG_TIMEOUT, (w < 2) ? 1 : $urandom_range(5, 60));
    write_reg(scp_pkg::REG_BRIGHT, $urandom_range(0, 7));
    write_reg(scp_pkg::REG_DIM, $urandom_range(0, 7));
    n = 0;
    while (n < quota) begin
      w = $urandom_range(0, 99);
      quiet = ($urandom_range(0, 99) < 15);
      noisy = 1'b0;
      span = ((tracker.debounce_cfg > 8) ? 8 : tracker.debounce_cfg) +
             tracker.hold_cfg + 6 * (tracker.repeat_cfg + 1) + 4;
      if ($urandom_range(0, 19) == 0) span = 200;
      if (w < 30) begin
        left_lvl = 1'b1; right_lvl = 1'b0; len = $urandom_range(1, span);
      end else if (w < 60) begin
        left_lvl = 1'b0; right_lvl = 1'b1; len = $urandom_range(1, span);
      end else if (w < 78) begin
        left_lvl = 1'b0; right_lvl = 1'b0;
        len = $urandom_range(1, tracker.timeout_cfg + 8);
      end else if (w < 90) begin
        left_lvl = 1'b1; right_lvl = 1'b1;
        len = $urandom_range(1, tracker.debounce_cfg % 16 + 4);
      end else begin
        noisy = 1'b1; len = $urandom_range(1, 8);
      end
      for (j = 0; j < len; j++) begin
        if (noisy) {left_lvl, right_lvl} = 2'($urandom_range(0, 3));
        send_tick(left_lvl, right_lvl);
        n++;
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    int unsigned k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset display: start score, idle and dim
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);

    // Zero debounce, zero repeat, clamped start score, timeout of one tick
    wait_idle();
    write_reg(scp_pkg::REG_START, 127);
    write_reg(scp_pkg::REG_DEBOUNCE, 0);
    write_reg(scp_pkg::REG_HOLD, 2);
    write_reg(scp_pkg::REG_REPEAT, 0);
    write_reg(scp_pkg::REG_TIMEOUT, 1);
    write_reg(scp_pkg::REG_BRIGHT, 7);
    write_reg(scp_pkg::REG_DIM, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);

    // Zero start score shown as dashes, widest hold, repeat and timeout, unused register
    wait_idle();
    write_reg(scp_pkg::REG_START, 0);
    write_reg(scp_pkg::REG_DEBOUNCE, 1);
    write_reg(scp_pkg::REG_HOLD, 65535);
    write_reg(scp_pkg::REG_REPEAT, 65535);
    write_reg(scp_pkg::REG_TIMEOUT, 65535);
    write_reg(scp_pkg::REG_BRIGHT, 0);
    write_reg(scp_pkg::REG_DIM, 7);
    write_reg(UNUSED_REG, 5);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // Auto repeat on a held right button, then release
    wait_idle();
    write_reg(scp_pkg::REG_DEBOUNCE, 2);
    write_reg(scp_pkg::REG_HOLD, 3);
    write_reg(scp_pkg::REG_REPEAT, 2);
    write_reg(scp_pkg::REG_TIMEOUT, 4);
    for (k = 0; k < 8; k++) send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);

    // Random settings and press sequences
    for (k = 0; k < 6; k++) random_phase(130);

    // Hold the left button through a long run of back to back repeat clicks
    wait_idle();
    write_reg(scp_pkg::REG_START, 50);
    write_reg(scp_pkg::REG_DEBOUNCE, 3);
    write_reg(scp_pkg::REG_HOLD, 20);
    write_reg(scp_pkg::REG_REPEAT, 1);
    write_reg(scp_pkg::REG_TIMEOUT, 65535);
    write_reg(scp_pkg::REG_BRIGHT, 5);
    write_reg(scp_pkg::REG_DIM, 1);
    quiet = 1'b1;
    for (k = 0; k < 40; k++) send_tick(1'b1, 1'b0);
    for (k = 0; k < 3; k++) send_tick(1'b0, 1'b0);
    quiet = 1'b0;

    wait_idle();
    $display("Ran %0d ticks and %0d register writes; %0d display items compared.",
             tracker.ticks_seen, reg_writes, tracker.views_checked);
    $display("Covered debounce, auto repeat, dual press, timeout, blink and readback.");
    if (tracker.errors == 0 && tracker.due_views.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
